/* rtl/limit_order_book_matcher_unit_defines.svh */
// assertion macros for the order book matcher
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// checked property, disabled while reset is asserted
`define OBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, also checked during reset
`define OBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/obm_pkg.sv */
// shared types and constants for the order book matcher
// no dependencies
package obm_pkg;

    localparam int SLOTS   = 32;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int ID_W    = 32;
    localparam int PRICE_W = 16;
    localparam int SHARE_W = 24;
    localparam int ARR_W   = 32;
    localparam int KIND_W  = 3;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    localparam logic [KIND_W-1:0] KIND_FILL      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESTED    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILLED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_CANCEL = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SUB,
        OP_KILL,
        OP_WRITE
    } t_op;

    // update broadcast to the cells
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [SHARE_W-1:0] shares;
        logic [ID_W-1:0]    id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [ARR_W-1:0]   arrival;
    } t_cmd;

    // search key broadcast to the cells
    typedef struct packed {
        logic               want_bid;
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   now;
    } t_key;

    // running search result handed from cell to cell
    typedef struct packed {
        logic               bfound;
        logic [IDX_W-1:0]   bidx;
        logic [PRICE_W-1:0] bprice;
        logic [ARR_W-1:0]   barr;
        logic [SHARE_W-1:0] bshares;
        logic [ID_W-1:0]    bid;
        logic               mfound;
        logic [IDX_W-1:0]   midx;
        logic [PRICE_W-1:0] mprice;
        logic [SHARE_W-1:0] mshares;
        logic               ffound;
        logic [IDX_W-1:0]   fidx;
    } t_cand;

endpackage

/* rtl/obm_cell.sv */
// one order slot plus one stage of the search chain
// depends on obm_pkg
module obm_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [obm_pkg::IDX_W-1:0] i_idx,
    input  obm_pkg::t_cmd          i_cmd,
    input  obm_pkg::t_key          i_key,
    input  obm_pkg::t_cand         i_cand,
    output obm_pkg::t_cand         o_cand,
    output logic                   o_valid
);
    import obm_pkg::*;

    logic               r_valid;
    logic [ID_W-1:0]    r_id;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [SHARE_W-1:0] r_shares;
    logic [ARR_W-1:0]   r_arr;
    t_cand              r_cand;
    t_cand              n_cand;

    logic               hit;
    logic [ARR_W-1:0]   age;
    logic [ARR_W-1:0]   bage;
    logic               better;
    logic               take;

    assign hit = (i_cmd.idx == i_idx);

    // slot valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (hit) begin
            case (i_cmd.op)
                OP_SUB:   r_valid <= (r_shares != i_cmd.shares);
                OP_KILL:  r_valid <= 1'b0;
                OP_WRITE: r_valid <= 1'b1;
                default:  r_valid <= r_valid;
            endcase
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (hit && i_cmd.op == OP_SUB) begin
            r_shares <= r_shares - i_cmd.shares;
        end else if (hit && i_cmd.op == OP_WRITE) begin
            r_id     <= i_cmd.id;
            r_side   <= i_cmd.side;
            r_price  <= i_cmd.price;
            r_shares <= i_cmd.shares;
            r_arr    <= i_cmd.arrival;
        end
    end

    // merge this slot into the running search result
    always_comb begin
        age    = i_key.now - r_arr;
        bage   = i_key.now - i_cand.barr;
        better = i_key.want_bid ? (r_price > i_cand.bprice) : (r_price < i_cand.bprice);
        take   = r_valid && (r_side == i_key.want_bid) &&
                 (!i_cand.bfound || better ||
                  (r_price == i_cand.bprice && age > bage));
        n_cand = i_cand;
        if (take) begin
            n_cand.bfound  = 1'b1;
            n_cand.bidx    = i_idx;
            n_cand.bprice  = r_price;
            n_cand.barr    = r_arr;
            n_cand.bshares = r_shares;
            n_cand.bid     = r_id;
        end
        if (!i_cand.mfound && r_valid && r_id == i_key.id) begin
            n_cand.mfound  = 1'b1;
            n_cand.midx    = i_idx;
            n_cand.mprice  = r_price;
            n_cand.mshares = r_shares;
        end
        if (!i_cand.ffound && !r_valid) begin
            n_cand.ffound = 1'b1;
            n_cand.fidx   = i_idx;
        end
    end

    // chain stage register
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand  = r_cand;
    assign o_valid = r_valid;

endmodule

/* rtl/limit_order_book_matcher_unit.sv */
// Price-time priority order book matcher: a row of 32 slot cells and a
// sequencer that sends a search wave down the row, one cell per cycle.
// Channels: input beats on s_*, tuser = func (0 add, 1 cancel); result beats
// on m_*, tuser = kind, tlast marks the final result of an input.
// Each search wave crosses the row of cells, then a decide step follows. A
// cancel takes one wave before its result. An add takes one wave per fill
// plus one more for the final result, with a new input taken the cycle
// after the last result is loaded.
// One input is worked on at a time; s_tready is high only while idle.
// Results sit in an output register; while the receiver stalls, the decide
// step waits and the book is not changed.
// Reset clears all slot valid bits, the arrival counter and both handshakes;
// the book is empty and the block is ready in the first cycle after reset.
// A remainder takes the free slot of lowest index; a cancel removes the
// lowest-index slot with the matching id.
// depends on obm_pkg, obm_cell and limit_order_book_matcher_unit_defines.svh
`include "limit_order_book_matcher_unit_defines.svh"
module limit_order_book_matcher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // oid[31:0], is_buy[32], price[48:33], shares[72:49], zero pad
    input  logic [obm_pkg::S_DATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_id[31:0], result_price[47:32], result_shares[71:48]
    output logic [obm_pkg::M_DATA_W-1:0]   m_tdata,
    // kind[2:0]
    output logic [obm_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);
    import obm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_func;
    logic [ID_W-1:0]    r_id;
    logic               r_buy;
    logic [PRICE_W-1:0] r_price;
    logic [SHARE_W-1:0] r_rem;
    logic [ARR_W-1:0]   r_now;
    logic               r_mvalid;
    logic [M_DATA_W-1:0] r_mdata;
    logic [KIND_W-1:0]  r_mkind;
    logic               r_mlast;

    t_cand              chain [SLOTS+1];
    logic [SLOTS-1:0]   slot_valid;
    t_cmd               cmd;
    t_key               key;
    t_cand              res;
    logic               can_load;
    logic               crosses;
    logic               do_fill;
    logic [SHARE_W-1:0] traded;
    logic               s_acc;

    assign s_tready = (r_state == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign can_load = !r_mvalid || m_tready;
    assign res      = chain[SLOTS];

    // search key and empty result at the head of the row
    always_comb begin
        key.want_bid = !r_buy;
        key.id       = r_id;
        key.now      = r_now;
        chain[0]     = '0;
    end

    // row of slot cells
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        obm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_cmd   (cmd),
            .i_key   (key),
            .i_cand  (chain[k]),
            .o_cand  (chain[k+1]),
            .o_valid (slot_valid[k])
        );
    end

    // decide step: trade, rest, or cancel
    always_comb begin
        crosses = res.bfound &&
                  (r_buy ? (r_price >= res.bprice) : (r_price <= res.bprice));
        traded  = (r_rem < res.bshares) ? r_rem : res.bshares;
        do_fill = (r_func == FUNC_ADD) && (r_rem != '0) && crosses;
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.id      = r_id;
        cmd.side    = r_buy;
        cmd.price   = r_price;
        cmd.arrival = r_now;
        if (r_state == ST_DECIDE && can_load) begin
            if (r_func == FUNC_CANCEL) begin
                if (res.mfound) begin
                    cmd.op  = OP_KILL;
                    cmd.idx = res.midx;
                end
            end else if (r_rem != '0 && crosses) begin
                cmd.op     = OP_SUB;
                cmd.idx    = res.bidx;
                cmd.shares = traded;
            end else if (r_rem != '0 && res.ffound) begin
                cmd.op     = OP_WRITE;
                cmd.idx    = res.fidx;
                cmd.shares = r_rem;
            end
        end
    end

    // sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_now    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (m_tready && r_state != ST_DECIDE) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_func  <= s_tuser;
                        r_id    <= s_tdata[31:0];
                        r_buy   <= s_tdata[32];
                        r_price <= s_tdata[48:33];
                        r_rem   <= s_tdata[72:49];
                        r_cnt   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(SLOTS - 1)) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (can_load) begin
                        r_mvalid <= 1'b1;
                        r_cnt    <= '0;
                        r_state  <= do_fill ? ST_SCAN : ST_IDLE;
                        r_mlast  <= !do_fill;
                        if (r_func == FUNC_CANCEL) begin
                            r_mkind <= res.mfound ? KIND_CANCELLED : KIND_NOT_FOUND;
                            r_mdata <= res.mfound ? {res.mshares, res.mprice, r_id}
                                                  : {SHARE_W'(0), PRICE_W'(0), r_id};
                        end else if (do_fill) begin
                            r_mkind <= KIND_FILL;
                            r_mdata <= {traded, res.bprice, res.bid};
                            r_rem   <= r_rem - traded;
                        end else if (r_rem == '0) begin
                            r_mkind <= KIND_FILLED;
                            r_mdata <= {SHARE_W'(0), r_price, r_id};
                        end else if (res.ffound) begin
                            r_mkind <= KIND_RESTED;
                            r_mdata <= {r_rem, r_price, r_id};
                            r_now   <= r_now + 1'b1;
                        end else begin
                            r_mkind <= KIND_FULL;
                            r_mdata <= {r_rem, r_price, r_id};
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_mkind;
    assign m_tlast  = r_mlast;

    // checks
    `OBM_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
    `OBM_ASSERT(a_fill_not_last, (m_tvalid && m_tuser == KIND_FILL) |-> !m_tlast, "fill marked last")
    `OBM_ASSERT(a_rest_needs_slot, (r_state == ST_DECIDE && cmd.op == OP_WRITE) |-> !slot_valid[cmd.idx], "rest into used slot")

endmodule
